[hdl/crfc_pkg.sv]
// Shared types, constants and the CRC-8 step function of the response frame checker.
package crfc_pkg;

  // Default frame limits.
  localparam int DEF_MAX_PAYLOAD = 11;
  localparam int DEF_MIN_FRAME   = 6;
  localparam int DEF_MAX_FRAME   = 20;

  // Configuration registers.
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_HEAD = 1'd1;
  localparam logic [7:0]  CRC_SEED_RESET      = 8'h57;
  localparam logic [15:0] EXPECTED_HEAD_RESET = 16'h5A6B;

  // CRC-8 polynomial x^8 + x^2 + x + 1, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Byte positions of the fixed frame fields.
  localparam int POS_HEAD_LO = 0;
  localparam int POS_HEAD_HI = 1;
  localparam int POS_TYPE_LO = 2;
  localparam int POS_TYPE_HI = 3;
  localparam int POS_LENGTH  = 4;
  localparam int POS_PAYLOAD = 5;

  // The length byte counts the payload plus the error and PEC bytes.
  localparam logic [7:0] LENGTH_OVERHEAD = 8'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_BAD_HEAD  = 3'd2,
    ST_BAD_PLEN  = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_BAD_PEC   = 3'd5
  } status_t;

  typedef struct packed {
    logic head_bad;
    logic plen_bad;
    logic pec_bad;
    logic len_seen;
  } flags_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_last;
  } in_word_t;

  typedef struct packed {
    logic        valid;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [3:0]  payload_index;
    logic        frame_done;
    logic [2:0]  status;
    logic [15:0] frame_type;
    logic [7:0]  device_error;
    logic [3:0]  payload_count;
  } result_t;

  // One byte through the CRC-8 register, eight shift steps on a byte.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[hdl/crfc_if.sv]
// Handshake interfaces for the received byte stream and the result stream.
interface crfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_last;

  modport source (output valid, rx_byte, frame_last, input ready);
  modport sink (input valid, rx_byte, frame_last, output ready);
endinterface

interface crfc_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [3:0]  payload_index;
  logic        frame_done;
  logic [2:0]  status;
  logic [15:0] frame_type;
  logic [7:0]  device_error;
  logic [3:0]  payload_count;

  modport source (output valid, payload_valid, payload_byte, payload_index, frame_done,
                  status, frame_type, device_error, payload_count, input ready);
  modport sink (input valid, payload_valid, payload_byte, payload_index, frame_done,
                status, frame_type, device_error, payload_count, output ready);
endinterface

[hdl/crfc_in_stage.sv]
// Input register: holds one received word until the parser takes it.
module crfc_in_stage import crfc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_word_t in_word,
  output logic     in_ready,
  input  logic     advance,
  output logic     take,
  output in_word_t word
);

  logic hold_valid;

  assign take     = hold_valid && advance;
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_word;
    end
  end

endmodule

[hdl/crfc_parser.sv]
// Frame state and per-byte decode: CRC update, field capture, checks and status.
module crfc_parser import crfc_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
  parameter int MIN_FRAME   = DEF_MIN_FRAME,
  parameter int MAX_FRAME   = DEF_MAX_FRAME
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  in_word_t    word,
  input  logic [7:0]  crc_seed,
  input  logic [15:0] expected_head,
  output result_t     res
);

  localparam int PW = $clog2(MAX_FRAME + 2);
  localparam int CW = (PW > 8 ? PW : 8) + 1;

  logic [PW-1:0] byte_position, byte_position_next;
  logic [7:0]    crc_running, crc_running_next;
  logic [15:0]   type_store, type_store_next;
  logic [7:0]    head_low_store, head_low_store_next;
  logic [7:0]    declared_payload, declared_payload_next;
  logic [7:0]    error_byte_store, error_byte_store_next;
  flags_t        fault_flags, fault_flags_next;
  logic          pec_seen, pec_seen_next;

  logic          pv;
  logic          is_pec;
  logic [7:0]    crc_in;
  logic [CW-1:0] off;
  logic [CW-1:0] dpx;
  status_t       st;

  always_comb begin
    byte_position_next    = byte_position;
    crc_running_next      = crc_running;
    type_store_next       = type_store;
    head_low_store_next   = head_low_store;
    declared_payload_next = declared_payload;
    error_byte_store_next = error_byte_store;
    fault_flags_next      = fault_flags;
    pec_seen_next         = pec_seen;
    pv                    = 1'b0;
    is_pec                = 1'b0;
    crc_in                = (byte_position == PW'(POS_HEAD_LO)) ? crc_seed : crc_running;
    off                   = CW'(byte_position) - CW'(POS_PAYLOAD);
    dpx                   = CW'(declared_payload);

    if (byte_position < PW'(MAX_FRAME) && !pec_seen) begin
      priority if (byte_position == PW'(POS_HEAD_LO)) begin
        head_low_store_next = word.rx_byte;
      end else if (byte_position == PW'(POS_HEAD_HI)) begin
        if ({word.rx_byte, head_low_store} != expected_head) begin
          fault_flags_next.head_bad = 1'b1;
        end
      end else if (byte_position == PW'(POS_TYPE_LO)) begin
        type_store_next[7:0] = word.rx_byte;
      end else if (byte_position == PW'(POS_TYPE_HI)) begin
        type_store_next[15:8] = word.rx_byte;
      end else if (byte_position == PW'(POS_LENGTH)) begin
        declared_payload_next     = word.rx_byte - LENGTH_OVERHEAD;
        fault_flags_next.len_seen = 1'b1;
        if (declared_payload_next > 8'(MAX_PAYLOAD)) begin
          fault_flags_next.plen_bad = 1'b1;
        end
      end else begin
        if (!fault_flags.plen_bad) begin
          priority if (off < dpx) begin
            pv = !fault_flags.head_bad;
          end else if (off == dpx) begin
            error_byte_store_next = word.rx_byte;
          end else if (off == dpx + CW'(1)) begin
            is_pec        = 1'b1;
            pec_seen_next = 1'b1;
            if (word.rx_byte != crc_running) begin
              fault_flags_next.pec_bad = 1'b1;
            end
          end
        end
      end
      if (!is_pec) begin
        crc_running_next = crc8_step(crc_in, word.rx_byte);
      end
    end

    if (byte_position < PW'(MAX_FRAME + 1)) begin
      byte_position_next = byte_position + PW'(1);
    end
  end

  // Status priority over the state as it stands after this byte.
  always_comb begin
    priority if (byte_position_next < PW'(MIN_FRAME) ||
                 byte_position_next > PW'(MAX_FRAME)) begin
      st = ST_BAD_LEN;
    end else if (fault_flags_next.head_bad) begin
      st = ST_BAD_HEAD;
    end else if (fault_flags_next.plen_bad) begin
      st = ST_BAD_PLEN;
    end else if (!pec_seen_next) begin
      st = ST_TRUNCATED;
    end else if (fault_flags_next.pec_bad) begin
      st = ST_BAD_PEC;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    res               = '0;
    res.valid         = pv || word.frame_last;
    res.payload_valid = pv;
    if (pv) begin
      res.payload_byte  = word.rx_byte;
      res.payload_index = off[3:0];
    end
    if (word.frame_last) begin
      res.frame_done   = 1'b1;
      res.status       = st;
      res.frame_type   = type_store_next;
      res.device_error = error_byte_store_next;
      if (fault_flags_next.len_seen && !fault_flags_next.plen_bad) begin
        res.payload_count = declared_payload_next[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && word.frame_last)) begin
      byte_position    <= '0;
      type_store       <= '0;
      head_low_store   <= '0;
      declared_payload <= '0;
      error_byte_store <= '0;
      fault_flags      <= '0;
      pec_seen         <= 1'b0;
    end else if (step) begin
      byte_position    <= byte_position_next;
      type_store       <= type_store_next;
      head_low_store   <= head_low_store_next;
      declared_payload <= declared_payload_next;
      error_byte_store <= error_byte_store_next;
      fault_flags      <= fault_flags_next;
      pec_seen         <= pec_seen_next;
    end
  end

  // The first byte of a frame always starts from the seed, so no clear is needed here.
  always_ff @(posedge clk) begin
    if (step) begin
      crc_running <= crc_running_next;
    end
  end

endmodule

[hdl/crfc_out_stage.sv]
// Result register: holds one result word until the downstream side takes it.
module crfc_out_stage import crfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t data,
  output logic    free
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      data <= res;
    end
  end

endmodule

[hdl/crc8_response_frame_checker.sv]
// Top level of the CRC-8 checked response frame checker.
//
//   Channel   Dir   Word contents
//   frame     in    rx_byte, frame_last
//   report    out   payload_valid/byte/index, frame_done, status, frame_type,
//                   device_error, payload_count
//   cfg_*     in    register write: index 0 crc_seed, index 1 expected_head
//
// The parser is combinational between the input register and the result register
// and is built around the one-byte CRC-8 update; a new byte is accepted every
// cycle while report is not stalled. A byte's result passes through the input
// register and then the result register on its way to the report port. Reset (rst,
// synchronous) clears the frame state, empties both registers and loads the
// default seed and head. When report is stalled the result register holds its
// word and the input register fills, after which frame.ready drops until the
// result is taken.
module crc8_response_frame_checker import crfc_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
  parameter int MIN_FRAME   = DEF_MIN_FRAME,
  parameter int MAX_FRAME   = DEF_MAX_FRAME
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  crfc_in_if.sink               frame,
  crfc_out_if.source            report
);

  // Configuration registers. They must be written only while the block is idle; the block does not enforce it.
  logic [7:0]  crc_seed;
  logic [15:0] expected_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed      <= CRC_SEED_RESET;
      expected_head <= EXPECTED_HEAD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CRC_SEED:      crc_seed      <= cfg_data[7:0];
        REG_EXPECTED_HEAD: expected_head <= cfg_data;
        default: ;
      endcase
    end
  end

  in_word_t in_word;
  in_word_t word;
  result_t  res;
  result_t  out_data;
  logic     take;
  logic     free;

  assign in_word.rx_byte    = frame.rx_byte;
  assign in_word.frame_last = frame.frame_last;

  // The input register advances whenever the result register can take a word;
  // bytes that produce no result pass through the parser all the same.
  crfc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .in_word  (in_word),
    .in_ready (frame.ready),
    .advance  (free),
    .take     (take),
    .word     (word)
  );

  crfc_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MIN_FRAME   (MIN_FRAME),
    .MAX_FRAME   (MAX_FRAME)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (take),
    .word          (word),
    .crc_seed      (crc_seed),
    .expected_head (expected_head),
    .res           (res)
  );

  crfc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res       (res),
    .out_ready (report.ready),
    .out_valid (report.valid),
    .data      (out_data),
    .free      (free)
  );

  assign report.payload_valid = out_data.payload_valid;
  assign report.payload_byte  = out_data.payload_byte;
  assign report.payload_index = out_data.payload_index;
  assign report.frame_done    = out_data.frame_done;
  assign report.status        = out_data.status;
  assign report.frame_type    = out_data.frame_type;
  assign report.device_error  = out_data.device_error;
  assign report.payload_count = out_data.payload_count;

  // A shown result always carries a payload byte, a frame status or both.
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    report.valid |-> (report.payload_valid || report.frame_done))
    else $error("result word carries neither payload nor status");

  // Payload fields read zero on a status-only word.
  a_status_only_clean: assert property (@(posedge clk) disable iff (rst)
    (report.valid && !report.payload_valid) |->
      (report.payload_byte == 8'd0 && report.payload_index == 4'd0))
    else $error("status-only word carries payload data");

  // A frame reported as good had a PEC and a payload count within bounds.
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    (report.valid && report.frame_done && report.status == ST_OK) |->
      (32'(report.payload_count) <= 32'(MAX_PAYLOAD)))
    else $error("good frame reports payload count out of range");

  // While the result register is stalled, no byte may be taken by the parser.
  a_stall_holds_parser: assert property (@(posedge clk) disable iff (rst)
    (report.valid && !report.ready) |-> !take)
    else $error("parser advanced while the result register was stalled");

endmodule
